/* sv/pba_pkg.sv */
// shared constants, word types and helper functions of the page bitmap allocator
package pba_pkg;

   localparam int NumPages = 8192;
   localparam int PageW    = $clog2(NumPages);
   localparam int CountW   = 14;
   localparam int WordW    = 32;
   localparam int BitW     = $clog2(WordW);
   localparam int WordsN   = NumPages / WordW;
   localparam int WaddrW   = $clog2(WordsN);
   // room for a page number, a run end and an aligned candidate past the map
   localparam int PosW     = PageW + 2;

   localparam int BootLastInt = ((16 * 1024 * 1024) >> 12) - 1;
   localparam int ResetNextInt = (BootLastInt < NumPages) ? BootLastInt : NumPages - 1;
   localparam logic [PageW-1:0]  ResetNext  = PageW'(ResetNextInt);
   localparam logic [CountW-1:0] TotalReset = CountW'(8192);

   localparam logic ModeAlloc = 1'b0;
   localparam logic ModeFree  = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [CountW-1:0] page_count;
      logic [CountW-1:0] align_pages;
      logic [PageW-1:0]  start_page;
   } req_type;

   typedef struct packed {
      logic             ok;
      logic [PageW-1:0] page_index;
   } rsp_type;

   // outcome of one scan step over the current map word
   typedef struct packed {
      logic            found;
      logic            pass_fail;
      logic            hit_used;
      logic [PosW-1:0] next_pos;
   } step_type;

   function automatic logic [PosW-1:0] align_up(input logic [PosW-1:0] v,
                                                input logic [PosW-1:0] m);
      return (v + m) & ~m;
   endfunction

   // mask below the highest set bit of the alignment, zero for an alignment of 0
   function automatic logic [CountW-1:0] eff_mask(input logic [CountW-1:0] a);
      logic [CountW-1:0] m;
      m = '0;
      for (int i = 0; i < CountW; i++) begin
         if (a[i]) begin
            m = CountW'((1 << i) - 1);
         end
      end
      return m;
   endfunction

endpackage

/* sv/pba_ram.sv */
// generic single write port, single read port ram with registered read
module pba_ram #(
   parameter int Width = 32,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/pba_run_step.sv */
// scan step unit: advances a free run across one map word
module pba_run_step import pba_pkg::*; (
   input  logic [WordW-1:0] word,
   input  logic [PosW-1:0]  pos,
   input  logic [PosW-1:0]  idx,
   input  logic [PosW-1:0]  cnt,
   input  logic [PosW-1:0]  stop_pos,
   output step_type         step_out
);

   logic [BitW-1:0]  bit_sel;
   logic [WordW-1:0] masked;
   logic [BitW:0]    first_used;
   logic [BitW:0]    avail;
   logic [PosW-1:0]  avail_ext;
   logic [PosW-1:0]  need;
   logic [PosW-1:0]  room;
   logic [PosW-1:0]  k_a;
   logic [PosW-1:0]  k;

   assign bit_sel = pos[BitW-1:0];
   assign masked  = word & ({WordW{1'b1}} << bit_sel);

   // lowest used page at or above the current one
   always_comb begin
      first_used = (BitW + 1)'(WordW);
      for (int i = WordW - 1; i >= 0; i--) begin
         if (masked[i]) begin
            first_used = (BitW + 1)'(i);
         end
      end
   end

   assign avail     = first_used - {1'b0, bit_sel};
   assign avail_ext = PosW'(avail);
   assign need      = cnt - (pos - idx);
   assign room      = stop_pos - pos;
   assign k_a       = (avail_ext < need) ? avail_ext : need;
   assign k         = (k_a < room) ? k_a : room;

   always_comb begin
      step_out.next_pos  = pos + k;
      step_out.found     = (k == need);
      step_out.pass_fail = (k != need) && (k == room);
      step_out.hit_used  = (k != need) && (k != room) && !first_used[BitW];
   end

endmodule

/* sv/pba_word_mask.sv */
// bit mask of the pages of one map word that fall inside a page range
module pba_word_mask import pba_pkg::*; (
   input  logic [PosW-BitW-1:0] word_addr,
   input  logic [PosW-1:0]      lo,
   input  logic [PosW-1:0]      hi,
   output logic [WordW-1:0]     mask
);

   logic [WordW-1:0] lo_m;
   logic [WordW-1:0] hi_m;

   always_comb begin
      if (lo[PosW-1:BitW] == word_addr) begin
         lo_m = {WordW{1'b1}} << lo[BitW-1:0];
      end else begin
         lo_m = {WordW{1'b1}};
      end
      if (hi[PosW-1:BitW] == word_addr) begin
         hi_m = ~({WordW{1'b1}} << hi[BitW-1:0]);
      end else begin
         hi_m = {WordW{1'b1}};
      end
      mask = lo_m & hi_m;
   end

endmodule

/* sv/page_bitmap_allocator.sv */
// page bitmap allocator top level: next-fit sequencer over a word-wide used map
// free: each map word in the range is read and written back; allocate scans map
//   words and hops past used pages over both passes, then marks the found run the
//   same way; a zero-page allocate is answered from idle without raising busy
// throughput: one word at a time, busy stays high until the result strobe
// reset: the used map is cleared by a pass of one word a cycle while busy
// results cannot be stalled: rsp_valid is a one-cycle strobe
module page_bitmap_allocator import pba_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request word
   input  logic              start,
   output logic              busy,
   input  req_type           req_word,
   // result word
   output logic              rsp_valid,
   output rsp_type           rsp_word,
   // page total register
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CountW-1:0] csr_total_pages
);

   // sequencer states
   localparam logic [2:0] StClear = 3'd0;
   localparam logic [2:0] StIdle  = 3'd1;
   localparam logic [2:0] StCheck = 3'd2;
   localparam logic [2:0] StScan  = 3'd3;
   localparam logic [2:0] StRmwRd = 3'd4;
   localparam logic [2:0] StRmwWr = 3'd5;

   localparam int WaW = PosW - BitW;

   logic [2:0]          state_ff, state_in;
   logic [WaddrW-1:0]   clr_ff, clr_in;
   logic [PageW-1:0]    ns_ff, ns_in;          // next-fit pointer
   logic [CountW-1:0]   total_ff, total_in;
   logic                pass_ff, pass_in;      // 0 upper pass, 1 wrap pass
   logic                cache_ok_ff, cache_ok_in;
   logic [WaddrW-1:0]   cache_addr_ff, cache_addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic [PosW-1:0]     cnt_ff, cnt_in;
   logic [PosW-1:0]     mask_ff, mask_in;
   logic [PosW-1:0]     idx_ff, idx_in;
   logic [PosW-1:0]     pos_ff, pos_in;
   logic [PosW-1:0]     stop_ff, stop_in;
   logic [PosW-1:0]     lo_ff, lo_in;
   logic [PosW-1:0]     hi_ff, hi_in;
   logic [PosW-1:0]     cur_ff, cur_in;
   logic                set_ff, set_in;        // mark used or free

   // ram side
   logic                ram_wr_en;
   logic [WaddrW-1:0]   ram_wr_addr;
   logic [WordW-1:0]    ram_wr_data;
   logic                ram_rd_en;
   logic [WaddrW-1:0]   ram_rd_addr;
   logic [WordW-1:0]    ram_rd_data;

   // helpers
   step_type            step;
   logic [WordW-1:0]    range_mask;
   logic [PosW-1:0]     limit;
   logic [PosW-1:0]     ns_ext;
   logic [PosW-1:0]     wrap_stop;
   logic [PosW-1:0]     req_mask;
   logic [PosW-1:0]     free_end;
   logic [PosW-1:0]     free_hi;
   logic [WaW-1:0]      cur_word;

   pba_ram #(
      .Width (WordW),
      .Depth (WordsN)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pba_run_step u_step (
      .word     (ram_rd_data),
      .pos      (pos_ff),
      .idx      (idx_ff),
      .cnt      (cnt_ff),
      .stop_pos (stop_ff),
      .step_out (step)
   );

   pba_word_mask u_mask (
      .word_addr (cur_word),
      .lo        (lo_ff),
      .hi        (hi_ff),
      .mask      (range_mask)
   );

   assign cur_word = cur_ff[PosW-1:BitW];

   // search bound: page total clipped to the map size
   assign limit     = (PosW'(total_ff) > PosW'(NumPages)) ? PosW'(NumPages) : PosW'(total_ff);
   assign ns_ext    = PosW'(ns_ff);
   assign wrap_stop = (ns_ext < limit) ? ns_ext : limit;
   assign req_mask  = PosW'(eff_mask(req_word.align_pages));
   assign free_end  = PosW'(req_word.start_page) + PosW'(req_word.page_count);
   assign free_hi   = (free_end > PosW'(NumPages)) ? PosW'(NumPages) : free_end;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      ns_in         = ns_ff;
      total_in      = total_ff;
      pass_in       = pass_ff;
      cache_ok_in   = cache_ok_ff;
      cache_addr_in = cache_addr_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      cnt_in        = cnt_ff;
      mask_in       = mask_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      stop_in       = stop_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      cur_in        = cur_ff;
      set_in        = set_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cur_word[WaddrW-1:0];
      ram_wr_data   = set_ff ? (ram_rd_data | range_mask) : (ram_rd_data & ~range_mask);
      ram_rd_en     = 1'b0;
      ram_rd_addr   = cur_word[WaddrW-1:0];

      if (csr_valid) begin
         total_in = csr_total_pages;
      end

      unique case (state_ff)
         StClear: begin
            // sweep zeros through the map
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + WaddrW'(1);
            if (clr_ff == WaddrW'(WordsN - 1)) begin
               state_in = StIdle;
            end
         end
         StIdle: begin
            if (start) begin
               cache_ok_in = 1'b0;
               if (req_word.mode == ModeFree) begin
                  lo_in    = PosW'(req_word.start_page);
                  hi_in    = free_hi;
                  cur_in   = PosW'(req_word.start_page);
                  set_in   = 1'b0;
                  rsp_in   = '{ok: 1'b1, page_index: '0};
                  state_in = StRmwRd;
               end else if (req_word.page_count == '0) begin
                  // zero-page allocate is rejected at once
                  rsp_in       = '{ok: 1'b0, page_index: '0};
                  rsp_valid_in = 1'b1;
               end else begin
                  cnt_in   = PosW'(req_word.page_count);
                  mask_in  = req_mask;
                  pass_in  = 1'b0;
                  stop_in  = limit;
                  idx_in   = align_up(ns_ext + PosW'(1), req_mask);
                  pos_in   = align_up(ns_ext + PosW'(1), req_mask);
                  state_in = StCheck;
               end
            end
         end
         StCheck: begin
            if (pos_ff >= stop_ff) begin
               // candidate past the bound: wrap or give up
               if (!pass_ff) begin
                  pass_in = 1'b1;
                  stop_in = wrap_stop;
                  idx_in  = '0;
                  pos_in  = '0;
               end else begin
                  rsp_in       = '{ok: 1'b0, page_index: '0};
                  rsp_valid_in = 1'b1;
                  state_in     = StIdle;
               end
            end else begin
               ram_rd_addr = pos_ff[BitW+WaddrW-1:BitW];
               if (!(cache_ok_ff && cache_addr_ff == ram_rd_addr)) begin
                  ram_rd_en     = 1'b1;
                  cache_ok_in   = 1'b1;
                  cache_addr_in = ram_rd_addr;
               end
               state_in = StScan;
            end
         end
         StScan: begin
            priority if (step.found) begin
               lo_in    = idx_ff;
               hi_in    = idx_ff + cnt_ff;
               cur_in   = idx_ff;
               set_in   = 1'b1;
               ns_in    = PageW'(idx_ff + cnt_ff - PosW'(1));
               rsp_in   = '{ok: 1'b1, page_index: idx_ff[PageW-1:0]};
               state_in = StRmwRd;
            end else if (step.pass_fail) begin
               if (!pass_ff) begin
                  pass_in  = 1'b1;
                  stop_in  = wrap_stop;
                  idx_in   = '0;
                  pos_in   = '0;
                  state_in = StCheck;
               end else begin
                  rsp_in       = '{ok: 1'b0, page_index: '0};
                  rsp_valid_in = 1'b1;
                  state_in     = StIdle;
               end
            end else if (step.hit_used) begin
               // restart past the used page at the next aligned page
               idx_in   = align_up(step.next_pos + PosW'(1), mask_ff);
               pos_in   = align_up(step.next_pos + PosW'(1), mask_ff);
               state_in = StCheck;
            end else begin
               // run reaches the word end, continue in the next word
               pos_in   = step.next_pos;
               state_in = StCheck;
            end
         end
         StRmwRd: begin
            cache_ok_in = 1'b0;
            if (cur_ff >= hi_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = StIdle;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = StRmwWr;
            end
         end
         StRmwWr: begin
            ram_wr_en = 1'b1;
            cur_in    = {cur_word + WaW'(1), {BitW{1'b0}}};
            state_in  = StRmwRd;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StClear;
         clr_ff       <= '0;
         ns_ff        <= ResetNext;
         total_ff     <= TotalReset;
         pass_ff      <= 1'b0;
         cache_ok_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ns_ff        <= ns_in;
         total_ff     <= total_in;
         pass_ff      <= pass_in;
         cache_ok_ff  <= cache_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      cache_addr_ff <= cache_addr_in;
      rsp_ff        <= rsp_in;
      cnt_ff        <= cnt_in;
      mask_ff       <= mask_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      stop_ff       <= stop_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      cur_ff        <= cur_in;
      set_ff        <= set_in;
   end

   assign busy      = (state_ff != StIdle);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule
